>>> sv/bracket_balance_checker_core_macros.svh
// ----------------------------------------------------------------------------
// bracket_balance_checker_core_macros
// Assertion macros shared by the bracket balance checker RTL.
// ----------------------------------------------------------------------------
`ifndef BRACKET_BALANCE_CHECKER_CORE_MACROS_SVH
`define BRACKET_BALANCE_CHECKER_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define BBC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bracket checker assertion failed");

// antecedent implies consequent in the next cycle
`define BBC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bracket checker assertion failed");

`endif

>>> sv/bbc_pkg.sv
// ----------------------------------------------------------------------------
// bbc_pkg
// Types, codes and decode functions of the bracket balance checker.
// ----------------------------------------------------------------------------
package bbc_pkg;

  localparam int STACK_DEPTH_DEF = 64;

  localparam int CHAR_W   = 8;
  localparam int STATUS_W = 2;

  typedef logic [1:0]          kind_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [CHAR_W-1:0]   char_t;

  localparam kind_t KIND_PAREN  = 2'd0;
  localparam kind_t KIND_BRACE  = 2'd1;
  localparam kind_t KIND_SQUARE = 2'd2;
  localparam kind_t KIND_NONE   = 2'd3;

  localparam status_t ST_PENDING    = 2'd0;
  localparam status_t ST_BALANCED   = 2'd1;
  localparam status_t ST_UNBALANCED = 2'd2;
  localparam status_t ST_OVERFLOW   = 2'd3;

  localparam char_t CHAR_NUL       = 8'h00;
  localparam char_t CHAR_PAREN_OP  = 8'h28;
  localparam char_t CHAR_PAREN_CL  = 8'h29;
  localparam char_t CHAR_SQUARE_OP = 8'h5B;
  localparam char_t CHAR_SQUARE_CL = 8'h5D;
  localparam char_t CHAR_BRACE_OP  = 8'h7B;
  localparam char_t CHAR_BRACE_CL  = 8'h7D;

  typedef struct packed {
    status_t status;
    logic    done_res;
  } result_t;

  function automatic kind_t open_kind(input char_t c);
    kind_t k;
    k = KIND_NONE;
    if (c == CHAR_PAREN_OP)  k = KIND_PAREN;
    if (c == CHAR_BRACE_OP)  k = KIND_BRACE;
    if (c == CHAR_SQUARE_OP) k = KIND_SQUARE;
    return k;
  endfunction

  function automatic kind_t close_kind(input char_t c);
    kind_t k;
    k = KIND_NONE;
    if (c == CHAR_PAREN_CL)  k = KIND_PAREN;
    if (c == CHAR_BRACE_CL)  k = KIND_BRACE;
    if (c == CHAR_SQUARE_CL) k = KIND_SQUARE;
    return k;
  endfunction

endpackage

>>> sv/bracket_balance_checker_core.sv
// ----------------------------------------------------------------------------
// bracket_balance_checker_core
// Streaming bracket balance checker, one byte per word, byte 0 ends a string.
// ----------------------------------------------------------------------------
// One byte is accepted per clock cycle while the output buffer can take it,
// including runs of pushes and pops; each byte gives one result word. The
// stack lives in a memory with one write and one registered read port; the
// top entry is also held in a register and the entry below it is read ahead
// every cycle, so a pop has its next top ready by the following cycle. The
// memory needs no clearing pass after reset. Results leave through a two-entry
// output buffer, so input keeps flowing while one result waits downstream.
module bracket_balance_checker_core #(
  parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] char_in
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [1:0] status, [7:2] zero
  output logic       m_tlast    // done_res
);
  import bbc_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  logic [CW-1:0] stack_count, stack_count_next;
  logic          mismatch_seen, mismatch_seen_next;
  logic          overflow_seen, overflow_seen_next;
  kind_t         tos, tos_next;
  kind_t         below;

  logic    accept, is_term, active, push, pop, room, wr_en;
  kind_t   kind_op, kind_cl;
  result_t res, out_res;
  logic [CW-1:0] rd_ptr;

  assign accept  = s_tvalid && s_tready;
  assign is_term = (s_tdata == CHAR_NUL);
  assign active  = !mismatch_seen && !overflow_seen;
  assign kind_op = open_kind(s_tdata);
  assign kind_cl = close_kind(s_tdata);
  assign push    = accept && !is_term && active && (kind_op != KIND_NONE);
  assign pop     = accept && !is_term && active && (kind_op == KIND_NONE) &&
                   (kind_cl != KIND_NONE);
  assign room    = (stack_count < FULL);
  assign wr_en   = push && room;

  always_comb begin
    stack_count_next   = stack_count;
    mismatch_seen_next = mismatch_seen;
    overflow_seen_next = overflow_seen;
    tos_next           = tos;
    res.status         = ST_PENDING;
    res.done_res       = 1'b0;
    if (accept && is_term) begin
      priority if (overflow_seen) begin
        res.status = ST_OVERFLOW;
      end else if (mismatch_seen || (stack_count != '0)) begin
        res.status = ST_UNBALANCED;
      end else begin
        res.status = ST_BALANCED;
      end
      res.done_res       = 1'b1;
      stack_count_next   = '0;
      mismatch_seen_next = 1'b0;
      overflow_seen_next = 1'b0;
    end else if (push) begin
      if (room) begin
        stack_count_next = stack_count + CW'(1);
        tos_next         = kind_op;
      end else begin
        overflow_seen_next = 1'b1;
      end
    end else if (pop) begin
      if (stack_count == '0) begin
        mismatch_seen_next = 1'b1;
      end else begin
        stack_count_next = stack_count - CW'(1);
        tos_next         = below;
        if (tos != kind_cl) mismatch_seen_next = 1'b1;
      end
    end
  end

  // read ahead the entry under the next top
  assign rd_ptr = stack_count_next - CW'(2);

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_count   <= '0;
      mismatch_seen <= 1'b0;
      overflow_seen <= 1'b0;
    end else begin
      stack_count   <= stack_count_next;
      mismatch_seen <= mismatch_seen_next;
      overflow_seen <= overflow_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    tos <= tos_next;
  end

  bbc_stack_ram #(
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (stack_count[AW-1:0]),
    .wr_data (kind_op),
    .rd_addr (rd_ptr[AW-1:0]),
    .rd_data (below)
  );

  bbc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_ready  (s_tready),
    .in_data   (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = {6'd0, out_res.status};
  assign m_tlast = out_res.done_res;

`include "bracket_balance_checker_core_macros.svh"

  `BBC_ASSERT_NEXT(a_term_clears, accept && is_term, (stack_count == '0) && active)
  `BBC_ASSERT_SAME(a_ovf_full, overflow_seen, stack_count == FULL)
  `BBC_ASSERT_NEXT(a_flag_freeze, accept && !is_term && !active, $stable(stack_count))
  `BBC_ASSERT_NEXT(a_push_top, wr_en, tos == $past(kind_op))

endmodule

>>> sv/bbc_stack_ram.sv
// ----------------------------------------------------------------------------
// bbc_stack_ram
// Bracket stack storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bbc_stack_ram #(
  parameter int DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  bbc_pkg::kind_t           wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output bbc_pkg::kind_t           rd_data
);
  import bbc_pkg::*;

  kind_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> sv/bbc_out_buf.sv
// ----------------------------------------------------------------------------
// bbc_out_buf
// Two-entry output buffer: output register plus skid stage.
// ----------------------------------------------------------------------------
module bbc_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  bbc_pkg::result_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output bbc_pkg::result_t out_data
);
  import bbc_pkg::*;

  logic    skid_valid;
  result_t skid_data;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      out_data <= skid_valid ? skid_data : in_data;
    end else if (in_valid && !skid_valid) begin
      skid_data <= in_data;
    end
  end

endmodule
